// ===== hw/rtl/bxtb_pkg.sv =====
// ---------------------------------------------------------------------------
// bxtb_pkg
// Shared constants, types and helpers for the box transform bounds pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package bxtb_pkg;

	localparam int CoordWidthDefault = 32;
	localparam int FieldWidth = 32;
	localparam int RotWidth = 16;
	localparam int RotFrac = 14;
	localparam int RoundHalf = 8192;
	localparam int RowWidth = 48;
	localparam int NumCorners = 8;
	localparam int NumAxes = 3;
	localparam int CfgDataWidth = 64;
	localparam int CfgAddrWidth = 6;
	localparam int RegIdxLsb = 3;

	localparam logic [RowWidth-1:0] StageRotRow0Reset = 48'h0000_0000_4000;
	localparam logic [RowWidth-1:0] StageRotRow1Reset = 48'h0000_4000_0000;
	localparam logic [RowWidth-1:0] StageRotRow2Reset = 48'h4000_0000_0000;

	typedef enum logic [2:0] {
		REG_STAGE_ROT_ROW0 = 3'd0,
		REG_STAGE_ROT_ROW1 = 3'd1,
		REG_STAGE_ROT_ROW2 = 3'd2,
		REG_STAGE_ORIGIN_X = 3'd3,
		REG_STAGE_ORIGIN_Y = 3'd4,
		REG_STAGE_ORIGIN_Z = 3'd5
	} reg_idx_t;

	// travels with each word down the pipe
	typedef struct packed {
		logic valid;
		logic sat;
	} tag_t;

	function automatic logic [RotWidth-1:0] rot_entry(input logic [RowWidth-1:0] row,
		input logic [1:0] col);
		return row[col*RotWidth +: RotWidth];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bxtb_clamp_add.sv =====
// ---------------------------------------------------------------------------
// bxtb_clamp_add
// Saturates a rounded row sum to the coordinate range, adds an origin and
// saturates again.
// ---------------------------------------------------------------------------
`default_nettype none

module bxtb_clamp_add #(
	parameter int COORD_WIDTH = bxtb_pkg::CoordWidthDefault
) (
	input  logic [COORD_WIDTH+bxtb_pkg::RotWidth+1-bxtb_pkg::RotFrac:0] rnd,
	input  logic [COORD_WIDTH-1:0] org,
	output logic [COORD_WIDTH-1:0] val,
	output logic sat
);

	localparam int CW = COORD_WIDTH;
	localparam int RW = CW + bxtb_pkg::RotWidth + 2 - bxtb_pkg::RotFrac;
	localparam int HW = RW - CW + 1;
	localparam logic [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

	logic ovf_rot;
	logic ovf_sum;
	logic [CW-1:0] rot_c;
	logic [CW:0] sum;

	assign ovf_rot = rnd[RW-1:CW-1] != {HW{rnd[RW-1]}};
	assign rot_c = ovf_rot ? (rnd[RW-1] ? CoordMin : CoordMax) : rnd[CW-1:0];
	assign sum = {rot_c[CW-1], rot_c} + {org[CW-1], org};
	assign ovf_sum = sum[CW] != sum[CW-1];
	assign val = ovf_sum ? (sum[CW] ? CoordMin : CoordMax) : sum[CW-1:0];
	assign sat = ovf_rot | ovf_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/bxtb_elem_xform.sv =====
// ---------------------------------------------------------------------------
// bxtb_elem_xform
// Element rotation and origin for all eight corners; the per-column products
// are shared between corners that pick the same bound.
// ---------------------------------------------------------------------------
`default_nettype none

module bxtb_elem_xform #(
	parameter int COORD_WIDTH = bxtb_pkg::CoordWidthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  bxtb_pkg::tag_t up_tag,
	output logic up_ready,
	input  logic [2:0][COORD_WIDTH-1:0] box_min,
	input  logic [2:0][COORD_WIDTH-1:0] box_max,
	input  logic [2:0][COORD_WIDTH-1:0] org,
	input  logic [2:0][bxtb_pkg::RowWidth-1:0] rot,
	output bxtb_pkg::tag_t dn_tag,
	input  logic dn_ready,
	output logic [bxtb_pkg::NumCorners-1:0][2:0][COORD_WIDTH-1:0] stg
);

	localparam int CW = COORD_WIDTH;
	localparam int NC = bxtb_pkg::NumCorners;
	localparam int NA = bxtb_pkg::NumAxes;
	localparam int PW = CW + bxtb_pkg::RotWidth;
	localparam int SW = PW + 2;
	localparam int RW = SW - bxtb_pkg::RotFrac;

	bxtb_pkg::tag_t tag_s2, tag_s3, tag_s4;
	logic rdy_s2, rdy_s3, rdy_s4;
	logic signed [PW-1:0] prod_s2 [NA][NA][2];
	logic [2:0][CW-1:0] org_s2, org_s3;
	logic signed [SW-1:0] sum_c [NC][NA];
	logic signed [RW-1:0] rnd_s3 [NC][NA];
	logic [NC-1:0][2:0][CW-1:0] val_c;
	logic [NC-1:0][2:0] sat_c;
	logic [NC-1:0][2:0][CW-1:0] stg_s4;

	assign rdy_s4 = !tag_s4.valid || dn_ready;
	assign rdy_s3 = !tag_s3.valid || rdy_s4;
	assign rdy_s2 = !tag_s2.valid || rdy_s3;
	assign up_ready = rdy_s2;

	for (genvar k = 0; k < NC; k++) begin : g_corner
		for (genvar a = 0; a < NA; a++) begin : g_row
			assign sum_c[k][a] = SW'(prod_s2[a][0][(k/4)%2]) + SW'(prod_s2[a][1][(k/2)%2])
				+ SW'(prod_s2[a][2][k%2]) + SW'(bxtb_pkg::RoundHalf);

			bxtb_clamp_add #(.COORD_WIDTH(CW)) u_clamp (
				.rnd(rnd_s3[k][a]),
				.org(org_s3[a]),
				.val(val_c[k][a]),
				.sat(sat_c[k][a])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			if (rdy_s2) tag_s2 <= up_tag;
			if (rdy_s3) tag_s3 <= tag_s2;
			if (rdy_s4) tag_s4 <= '{valid: tag_s3.valid, sat: tag_s3.sat | (|sat_c)};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && up_tag.valid) begin
			for (int r = 0; r < NA; r++) begin
				for (int c = 0; c < NA; c++) begin
					prod_s2[r][c][0] <= $signed(bxtb_pkg::rot_entry(rot[r], 2'(c)))
						* $signed(box_min[c]);
					prod_s2[r][c][1] <= $signed(bxtb_pkg::rot_entry(rot[r], 2'(c)))
						* $signed(box_max[c]);
				end
			end
			org_s2 <= org;
		end
		if (rdy_s3 && tag_s2.valid) begin
			for (int k = 0; k < NC; k++) begin
				for (int a = 0; a < NA; a++) begin
					rnd_s3[k][a] <= sum_c[k][a][SW-1:bxtb_pkg::RotFrac];
				end
			end
			org_s3 <= org_s2;
		end
		if (rdy_s4 && tag_s3.valid) begin
			stg_s4 <= val_c;
		end
	end

	assign dn_tag = tag_s4;
	assign stg = stg_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/bxtb_stage_xform.sv =====
// ---------------------------------------------------------------------------
// bxtb_stage_xform
// Stage rotation and origin applied to each of the eight corners.
// ---------------------------------------------------------------------------
`default_nettype none

module bxtb_stage_xform #(
	parameter int COORD_WIDTH = bxtb_pkg::CoordWidthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  bxtb_pkg::tag_t up_tag,
	output logic up_ready,
	input  logic [bxtb_pkg::NumCorners-1:0][2:0][COORD_WIDTH-1:0] stg,
	input  logic [2:0][bxtb_pkg::RowWidth-1:0] rot,
	input  logic [2:0][COORD_WIDTH-1:0] org,
	output bxtb_pkg::tag_t dn_tag,
	input  logic dn_ready,
	output logic [bxtb_pkg::NumCorners-1:0][2:0][COORD_WIDTH-1:0] glb
);

	localparam int CW = COORD_WIDTH;
	localparam int NC = bxtb_pkg::NumCorners;
	localparam int NA = bxtb_pkg::NumAxes;
	localparam int PW = CW + bxtb_pkg::RotWidth;
	localparam int SW = PW + 2;
	localparam int RW = SW - bxtb_pkg::RotFrac;

	bxtb_pkg::tag_t tag_s5, tag_s6, tag_s7;
	logic rdy_s5, rdy_s6, rdy_s7;
	logic signed [PW-1:0] prod_s5 [NC][NA][NA];
	logic signed [SW-1:0] sum_c [NC][NA];
	logic signed [RW-1:0] rnd_s6 [NC][NA];
	logic [NC-1:0][2:0][CW-1:0] val_c;
	logic [NC-1:0][2:0] sat_c;
	logic [NC-1:0][2:0][CW-1:0] glb_s7;

	assign rdy_s7 = !tag_s7.valid || dn_ready;
	assign rdy_s6 = !tag_s6.valid || rdy_s7;
	assign rdy_s5 = !tag_s5.valid || rdy_s6;
	assign up_ready = rdy_s5;

	for (genvar k = 0; k < NC; k++) begin : g_corner
		for (genvar a = 0; a < NA; a++) begin : g_row
			assign sum_c[k][a] = SW'(prod_s5[k][a][0]) + SW'(prod_s5[k][a][1])
				+ SW'(prod_s5[k][a][2]) + SW'(bxtb_pkg::RoundHalf);

			bxtb_clamp_add #(.COORD_WIDTH(CW)) u_clamp (
				.rnd(rnd_s6[k][a]),
				.org(org[a]),
				.val(val_c[k][a]),
				.sat(sat_c[k][a])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else begin
			if (rdy_s5) tag_s5 <= up_tag;
			if (rdy_s6) tag_s6 <= tag_s5;
			if (rdy_s7) tag_s7 <= '{valid: tag_s6.valid, sat: tag_s6.sat | (|sat_c)};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && up_tag.valid) begin
			for (int k = 0; k < NC; k++) begin
				for (int a = 0; a < NA; a++) begin
					for (int c = 0; c < NA; c++) begin
						prod_s5[k][a][c] <= $signed(bxtb_pkg::rot_entry(rot[a], 2'(c)))
							* $signed(stg[k][c]);
					end
				end
			end
		end
		if (rdy_s6 && tag_s5.valid) begin
			for (int k = 0; k < NC; k++) begin
				for (int a = 0; a < NA; a++) begin
					rnd_s6[k][a] <= sum_c[k][a][SW-1:bxtb_pkg::RotFrac];
				end
			end
		end
		if (rdy_s7 && tag_s6.valid) begin
			glb_s7 <= val_c;
		end
	end

	assign dn_tag = tag_s7;
	assign glb = glb_s7;

endmodule

`default_nettype wire

// ===== hw/rtl/bxtb_bounds.sv =====
// ---------------------------------------------------------------------------
// bxtb_bounds
// Per-axis minimum and maximum over the eight corners as a registered tree,
// then the clamp to the 32-bit output range; the last stage is the output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module bxtb_bounds #(
	parameter int COORD_WIDTH = bxtb_pkg::CoordWidthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  bxtb_pkg::tag_t up_tag,
	output logic up_ready,
	input  logic [bxtb_pkg::NumCorners-1:0][2:0][COORD_WIDTH-1:0] glb,
	output bxtb_pkg::tag_t dn_tag,
	input  logic dn_ready,
	output logic [2:0][bxtb_pkg::FieldWidth-1:0] bnd_min,
	output logic [2:0][bxtb_pkg::FieldWidth-1:0] bnd_max
);

	localparam int CW = COORD_WIDTH;
	localparam int FW = bxtb_pkg::FieldWidth;
	localparam int NA = bxtb_pkg::NumAxes;

	bxtb_pkg::tag_t tag_s8, tag_s9;
	logic rdy_s8, rdy_s9;
	logic [2:0][3:0][CW-1:0] lo1_c, hi1_c;
	logic [2:0][1:0][CW-1:0] lo2_c, hi2_c;
	logic [2:0][1:0][CW-1:0] lo_s8, hi_s8;
	logic [1:0][2:0][CW-1:0] fin_c;
	logic [1:0][2:0][FW-1:0] out_c;
	logic [1:0][2:0] ovf_c;
	logic [2:0][FW-1:0] min_s9, max_s9;

	assign rdy_s9 = !tag_s9.valid || dn_ready;
	assign rdy_s8 = !tag_s8.valid || rdy_s9;
	assign up_ready = rdy_s8;

	for (genvar a = 0; a < NA; a++) begin : g_axis
		for (genvar j = 0; j < 4; j++) begin : g_lvl1
			assign lo1_c[a][j] = ($signed(glb[2*j][a]) < $signed(glb[2*j+1][a]))
				? glb[2*j][a] : glb[2*j+1][a];
			assign hi1_c[a][j] = ($signed(glb[2*j][a]) > $signed(glb[2*j+1][a]))
				? glb[2*j][a] : glb[2*j+1][a];
		end
		for (genvar j = 0; j < 2; j++) begin : g_lvl2
			assign lo2_c[a][j] = ($signed(lo1_c[a][2*j]) < $signed(lo1_c[a][2*j+1]))
				? lo1_c[a][2*j] : lo1_c[a][2*j+1];
			assign hi2_c[a][j] = ($signed(hi1_c[a][2*j]) > $signed(hi1_c[a][2*j+1]))
				? hi1_c[a][2*j] : hi1_c[a][2*j+1];
		end
		assign fin_c[0][a] = ($signed(lo_s8[a][0]) < $signed(lo_s8[a][1]))
			? lo_s8[a][0] : lo_s8[a][1];
		assign fin_c[1][a] = ($signed(hi_s8[a][0]) > $signed(hi_s8[a][1]))
			? hi_s8[a][0] : hi_s8[a][1];

		for (genvar m = 0; m < 2; m++) begin : g_out
			if (CW > FW) begin : g_clamp
				assign ovf_c[m][a] = fin_c[m][a][CW-1:FW-1] != {(CW-FW+1){fin_c[m][a][CW-1]}};
				assign out_c[m][a] = ovf_c[m][a]
					? (fin_c[m][a][CW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}})
					: fin_c[m][a][FW-1:0];
			end else begin : g_ext
				assign ovf_c[m][a] = 1'b0;
				assign out_c[m][a] = FW'($signed(fin_c[m][a]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s8 <= '0;
			tag_s9 <= '0;
		end else begin
			if (rdy_s8) tag_s8 <= up_tag;
			if (rdy_s9) tag_s9 <= '{valid: tag_s8.valid, sat: tag_s8.sat | (|ovf_c)};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s8 && up_tag.valid) begin
			lo_s8 <= lo2_c;
			hi_s8 <= hi2_c;
		end
		if (rdy_s9 && tag_s8.valid) begin
			min_s9 <= out_c[0];
			max_s9 <= out_c[1];
		end
	end

	assign dn_tag = tag_s9;
	assign bnd_min = min_s9;
	assign bnd_max = max_s9;

endmodule

`default_nettype wire

// ===== hw/rtl/box_transform_bounds.sv =====
// ---------------------------------------------------------------------------
// box_transform_bounds
// Global axis-aligned bounds of a box placed by an element transform and a
// configurable stage transform, taken over the box's eight corners.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------
//   item     | item_valid / item_stall     | box bounds, element rows, origin
//   bound    | bound_valid / bound_stall   | global bounds, saturated
//   config   | psel penable pwrite pready  | paddr, pwdata, prdata (64 bit)
//
// One word enters per cycle while item_stall is low.
// All eight corners run in parallel lanes, so the multiplier lanes set the
// rate and the latency is the nine register stages of the pipe.
// Reset clears all valid bits and loads an identity stage transform.
// A stall holds only the stages that are full; empty stages keep filling.
// ---------------------------------------------------------------------------
`default_nettype none

module box_transform_bounds #(
	parameter int COORD_WIDTH = bxtb_pkg::CoordWidthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic [31:0] box_min_x,
	input  logic [31:0] box_min_y,
	input  logic [31:0] box_min_z,
	input  logic [31:0] box_max_x,
	input  logic [31:0] box_max_y,
	input  logic [31:0] box_max_z,
	input  logic [47:0] elem_rot_row0,
	input  logic [47:0] elem_rot_row1,
	input  logic [47:0] elem_rot_row2,
	input  logic [31:0] elem_origin_x,
	input  logic [31:0] elem_origin_y,
	input  logic [31:0] elem_origin_z,
	output logic bound_valid,
	input  logic bound_stall,
	output logic [31:0] glob_min_x,
	output logic [31:0] glob_min_y,
	output logic [31:0] glob_min_z,
	output logic [31:0] glob_max_x,
	output logic [31:0] glob_max_y,
	output logic [31:0] glob_max_z,
	output logic saturated,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [bxtb_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [bxtb_pkg::CfgDataWidth-1:0] pwdata,
	output logic [bxtb_pkg::CfgDataWidth-1:0] prdata,
	output logic pready
);

	localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 48) ? 48 : COORD_WIDTH);
	localparam int FW = bxtb_pkg::FieldWidth;
	localparam int RWD = bxtb_pkg::RowWidth;
	localparam int NC = bxtb_pkg::NumCorners;
	localparam int NIN = 12;
	localparam logic [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

	logic [2:0][RWD-1:0] stage_rot_q;
	logic [2:0][FW-1:0] stage_origin_q;
	logic cfg_wr;
	bxtb_pkg::reg_idx_t cfg_idx;

	logic [NIN-1:0][FW-1:0] raw;
	logic [NIN-1:0][CW-1:0] clp;
	logic [NIN-1:0] ovf;

	bxtb_pkg::tag_t tag_s1, elem_tag, stage_tag, bnd_tag;
	logic rdy_s1, elem_ready, stage_ready, bnd_ready;
	logic [2:0][CW-1:0] min_s1, max_s1, eorg_s1, sorg_c;
	logic [2:0][RWD-1:0] rot_s1;
	logic [NC-1:0][2:0][CW-1:0] stg, glb;
	logic [2:0][FW-1:0] bnd_min, bnd_max;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = bxtb_pkg::reg_idx_t'(paddr[bxtb_pkg::CfgAddrWidth-1:bxtb_pkg::RegIdxLsb]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_rot_q[0] <= bxtb_pkg::StageRotRow0Reset;
			stage_rot_q[1] <= bxtb_pkg::StageRotRow1Reset;
			stage_rot_q[2] <= bxtb_pkg::StageRotRow2Reset;
			stage_origin_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bxtb_pkg::REG_STAGE_ROT_ROW0: stage_rot_q[0] <= pwdata[RWD-1:0];
				bxtb_pkg::REG_STAGE_ROT_ROW1: stage_rot_q[1] <= pwdata[RWD-1:0];
				bxtb_pkg::REG_STAGE_ROT_ROW2: stage_rot_q[2] <= pwdata[RWD-1:0];
				bxtb_pkg::REG_STAGE_ORIGIN_X: stage_origin_q[0] <= pwdata[FW-1:0];
				bxtb_pkg::REG_STAGE_ORIGIN_Y: stage_origin_q[1] <= pwdata[FW-1:0];
				bxtb_pkg::REG_STAGE_ORIGIN_Z: stage_origin_q[2] <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			bxtb_pkg::REG_STAGE_ROT_ROW0: prdata = 64'(stage_rot_q[0]);
			bxtb_pkg::REG_STAGE_ROT_ROW1: prdata = 64'(stage_rot_q[1]);
			bxtb_pkg::REG_STAGE_ROT_ROW2: prdata = 64'(stage_rot_q[2]);
			bxtb_pkg::REG_STAGE_ORIGIN_X: prdata = 64'(stage_origin_q[0]);
			bxtb_pkg::REG_STAGE_ORIGIN_Y: prdata = 64'(stage_origin_q[1]);
			bxtb_pkg::REG_STAGE_ORIGIN_Z: prdata = 64'(stage_origin_q[2]);
			default: prdata = '0;
		endcase
	end

	// input coordinates into the internal range
	assign raw[0] = box_min_x;
	assign raw[1] = box_min_y;
	assign raw[2] = box_min_z;
	assign raw[3] = box_max_x;
	assign raw[4] = box_max_y;
	assign raw[5] = box_max_z;
	assign raw[6] = elem_origin_x;
	assign raw[7] = elem_origin_y;
	assign raw[8] = elem_origin_z;
	assign raw[9] = stage_origin_q[0];
	assign raw[10] = stage_origin_q[1];
	assign raw[11] = stage_origin_q[2];

	for (genvar i = 0; i < NIN; i++) begin : g_in
		if (CW >= FW) begin : g_ext
			assign ovf[i] = 1'b0;
			assign clp[i] = CW'($signed(raw[i]));
		end else begin : g_clamp
			assign ovf[i] = raw[i][FW-1:CW-1] != {(FW-CW+1){raw[i][FW-1]}};
			assign clp[i] = ovf[i] ? (raw[i][FW-1] ? CoordMin : CoordMax) : raw[i][CW-1:0];
		end
	end

	assign sorg_c[0] = clp[9];
	assign sorg_c[1] = clp[10];
	assign sorg_c[2] = clp[11];

	// input stage
	assign rdy_s1 = !tag_s1.valid || elem_ready;
	assign item_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (rdy_s1) begin
			tag_s1 <= '{valid: item_valid, sat: |ovf};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			for (int a = 0; a < 3; a++) begin
				min_s1[a] <= clp[a];
				max_s1[a] <= clp[3+a];
				eorg_s1[a] <= clp[6+a];
			end
			rot_s1[0] <= elem_rot_row0;
			rot_s1[1] <= elem_rot_row1;
			rot_s1[2] <= elem_rot_row2;
		end
	end

	bxtb_elem_xform #(.COORD_WIDTH(CW)) u_elem (
		.clk(clk),
		.arst_n(arst_n),
		.up_tag(tag_s1),
		.up_ready(elem_ready),
		.box_min(min_s1),
		.box_max(max_s1),
		.org(eorg_s1),
		.rot(rot_s1),
		.dn_tag(elem_tag),
		.dn_ready(stage_ready),
		.stg(stg)
	);

	bxtb_stage_xform #(.COORD_WIDTH(CW)) u_stage (
		.clk(clk),
		.arst_n(arst_n),
		.up_tag(elem_tag),
		.up_ready(stage_ready),
		.stg(stg),
		.rot(stage_rot_q),
		.org(sorg_c),
		.dn_tag(stage_tag),
		.dn_ready(bnd_ready),
		.glb(glb)
	);

	bxtb_bounds #(.COORD_WIDTH(CW)) u_bounds (
		.clk(clk),
		.arst_n(arst_n),
		.up_tag(stage_tag),
		.up_ready(bnd_ready),
		.glb(glb),
		.dn_tag(bnd_tag),
		.dn_ready(!bound_stall),
		.bnd_min(bnd_min),
		.bnd_max(bnd_max)
	);

	assign bound_valid = bnd_tag.valid;
	assign saturated = bnd_tag.sat;
	assign glob_min_x = bnd_min[0];
	assign glob_min_y = bnd_min[1];
	assign glob_min_z = bnd_min[2];
	assign glob_max_x = bnd_max[0];
	assign glob_max_y = bnd_max[1];
	assign glob_max_z = bnd_max[2];

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> tag_s1.valid)
		else $error("accepted word missing from input stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> tag_s1.valid)
		else $error("input stalled with empty input stage");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		bound_valid |-> (($signed(glob_min_x) <= $signed(glob_max_x))
			&& ($signed(glob_min_y) <= $signed(glob_max_y))
			&& ($signed(glob_min_z) <= $signed(glob_max_z))))
		else $error("output minimum above maximum");

endmodule

`default_nettype wire

// ===== sim/tb_box_transform_bounds.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_box_transform_bounds
// Self-checking bench for the box transform bounds pipeline. Box words are
// sent with random gaps and the bound words are taken under random stalls.
// A bit-exact fixed-point predictor works out the global bounds and the
// saturation flag for every accepted word, and each bound word is checked
// field by field against the oldest prediction. The stage transform is
// reprogrammed over the config port between drained phases, covering the
// reset identity, the extreme settings and random settings.
// ---------------------------------------------------------------------------

module tb_box_transform_bounds;

	localparam int CW = bxtb_pkg::CoordWidthDefault;
	localparam int CW_EFF = (CW < 16) ? 16 : ((CW > 48) ? 48 : CW);
	localparam longint COORD_MAX = (longint'(1) << (CW_EFF - 1)) - 1;
	localparam int LAT_SLACK = 16;
	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 236;

	localparam logic [2:0][47:0] IDENT_ROWS = {bxtb_pkg::StageRotRow2Reset,
		bxtb_pkg::StageRotRow1Reset, bxtb_pkg::StageRotRow0Reset};
	localparam logic [2:0][47:0] NEG_TWO_ROWS = {3{48'h8000_8000_8000}};
	localparam logic [2:0][47:0] MAX_ROWS = {3{48'h7FFF_7FFF_7FFF}};

	typedef struct packed {
		logic [2:0][31:0] bmin;
		logic [2:0][31:0] bmax;
		logic [2:0][47:0] rot;
		logic [2:0][31:0] org;
	} box_word_t;

	typedef struct packed {
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		logic sat;
	} bounds_t;

	typedef logic [2:0][63:0] vec3_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [31:0] box_min_x = '0;
	logic [31:0] box_min_y = '0;
	logic [31:0] box_min_z = '0;
	logic [31:0] box_max_x = '0;
	logic [31:0] box_max_y = '0;
	logic [31:0] box_max_z = '0;
	logic [47:0] elem_rot_row0 = '0;
	logic [47:0] elem_rot_row1 = '0;
	logic [47:0] elem_rot_row2 = '0;
	logic [31:0] elem_origin_x = '0;
	logic [31:0] elem_origin_y = '0;
	logic [31:0] elem_origin_z = '0;
	logic bound_valid;
	logic bound_stall = 1'b0;
	logic [31:0] glob_min_x;
	logic [31:0] glob_min_y;
	logic [31:0] glob_min_z;
	logic [31:0] glob_max_x;
	logic [31:0] glob_max_y;
	logic [31:0] glob_max_z;
	logic saturated;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [bxtb_pkg::CfgAddrWidth-1:0] paddr = '0;
	logic [bxtb_pkg::CfgDataWidth-1:0] pwdata = '0;
	logic [bxtb_pkg::CfgDataWidth-1:0] prdata;
	logic pready;

	logic [2:0][47:0] stage_rot = IDENT_ROWS;
	logic [2:0][31:0] stage_org = '0;
	logic clamp_hit;
	bounds_t bound_due[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	bit sink_hold_req = 1'b0;
	int sink_hold_left = 0;
	int sink_run = 0;
	bit sink_busy = 1'b0;
	string min_name[3] = '{"glob_min_x", "glob_min_y", "glob_min_z"};
	string max_name[3] = '{"glob_max_x", "glob_max_y", "glob_max_z"};

	box_transform_bounds #(
		.COORD_WIDTH(CW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.box_min_x(box_min_x),
		.box_min_y(box_min_y),
		.box_min_z(box_min_z),
		.box_max_x(box_max_x),
		.box_max_y(box_max_y),
		.box_max_z(box_max_z),
		.elem_rot_row0(elem_rot_row0),
		.elem_rot_row1(elem_rot_row1),
		.elem_rot_row2(elem_rot_row2),
		.elem_origin_x(elem_origin_x),
		.elem_origin_y(elem_origin_y),
		.elem_origin_z(elem_origin_z),
		.bound_valid(bound_valid),
		.bound_stall(bound_stall),
		.glob_min_x(glob_min_x),
		.glob_min_y(glob_min_y),
		.glob_min_z(glob_min_z),
		.glob_max_x(glob_max_x),
		.glob_max_y(glob_max_y),
		.glob_max_z(glob_max_z),
		.saturated(saturated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------- fixed-point predictor ----------------

	function automatic longint clamp_range(longint v, longint lo, longint hi);
		if (v > hi) begin
			clamp_hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clamp_hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint clamp_coord(longint v);
		return clamp_range(v, -COORD_MAX - 1, COORD_MAX);
	endfunction

	function automatic longint rot_q(logic [47:0] row, int c);
		return longint'($signed(row[c*bxtb_pkg::RotWidth +: bxtb_pkg::RotWidth]));
	endfunction

	// row times vector, Q.30 rounded half up to Q16.16
	function automatic longint row_dot(logic [47:0] row, vec3_t v);
		longint p;
		longint qs;
		longint rs;
		qs = 0;
		rs = 0;
		for (int c = 0; c < bxtb_pkg::NumAxes; c++) begin
			p = rot_q(row, c) * $signed(v[c]);
			qs += p >>> bxtb_pkg::RotFrac;
			rs += p & ((longint'(1) << bxtb_pkg::RotFrac) - 1);
		end
		qs += (rs + bxtb_pkg::RoundHalf) >>> bxtb_pkg::RotFrac;
		return clamp_coord(qs);
	endfunction

	function automatic vec3_t place(logic [2:0][47:0] rows, vec3_t org, vec3_t v);
		vec3_t res;
		for (int a = 0; a < bxtb_pkg::NumAxes; a++)
			res[a] = clamp_coord(row_dot(rows[a], v) + $signed(org[a]));
		return res;
	endfunction

	function automatic bounds_t predict_bounds(box_word_t w);
		vec3_t bmin, bmax, eorg, sorg, corner, stg, glb, lo, hi;
		bounds_t res;
		clamp_hit = 1'b0;
		for (int a = 0; a < bxtb_pkg::NumAxes; a++) begin
			bmin[a] = clamp_coord(longint'($signed(w.bmin[a])));
			bmax[a] = clamp_coord(longint'($signed(w.bmax[a])));
			eorg[a] = clamp_coord(longint'($signed(w.org[a])));
			sorg[a] = clamp_coord(longint'($signed(stage_org[a])));
		end
		for (int k = 0; k < bxtb_pkg::NumCorners; k++) begin
			corner[0] = (k & 4) ? bmax[0] : bmin[0];
			corner[1] = (k & 2) ? bmax[1] : bmin[1];
			corner[2] = (k & 1) ? bmax[2] : bmin[2];
			stg = place(w.rot, eorg, corner);
			glb = place(stage_rot, sorg, stg);
			for (int a = 0; a < bxtb_pkg::NumAxes; a++) begin
				if (k == 0 || $signed(glb[a]) < $signed(lo[a]))
					lo[a] = glb[a];
				if (k == 0 || $signed(glb[a]) > $signed(hi[a]))
					hi[a] = glb[a];
			end
		end
		for (int a = 0; a < bxtb_pkg::NumAxes; a++) begin
			res.lo[a] = 32'(clamp_range($signed(lo[a]), -64'sd2147483648, 64'sd2147483647));
			res.hi[a] = 32'(clamp_range($signed(hi[a]), -64'sd2147483648, 64'sd2147483647));
		end
		res.sat = clamp_hit;
		return res;
	endfunction

	// ---------------- random content ----------------

	// mostly short, a few long
	function automatic int idle_len();
		if ($urandom_range(0, 19) < 17)
			return $urandom_range(0, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] coord_rand();
		int sh;
		logic [31:0] r;
		r = $urandom;
		sh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(8, 24);
		return 32'($signed(r) >>> sh);
	endfunction

	function automatic logic [47:0] rot_row_rand();
		logic [47:0] row;
		for (int c = 0; c < bxtb_pkg::NumAxes; c++) begin
			case ($urandom_range(0, 3))
				0: row[c*16 +: 16] = 16'h0000;
				1: row[c*16 +: 16] = 16'h4000;
				2: row[c*16 +: 16] = 16'hC000;
				default: row[c*16 +: 16] = 16'($urandom_range(0, 32768) - 16384);
			endcase
		end
		return row;
	endfunction

	function automatic logic [47:0] bits48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic box_word_t random_box();
		box_word_t w;
		logic [31:0] a, b;
		bit raw;
		raw = ($urandom_range(0, 99) < 15);
		for (int i = 0; i < bxtb_pkg::NumAxes; i++) begin
			if (raw) begin
				w.bmin[i] = $urandom;
				w.bmax[i] = $urandom;
				w.rot[i] = bits48();
				w.org[i] = $urandom;
			end else begin
				a = coord_rand();
				b = coord_rand();
				// mostly ordered boxes, some inverted
				if (($signed(a) > $signed(b)) != ($urandom_range(0, 9) == 0)) begin
					w.bmin[i] = b;
					w.bmax[i] = a;
				end else begin
					w.bmin[i] = a;
					w.bmax[i] = b;
				end
				w.rot[i] = rot_row_rand();
				w.org[i] = coord_rand();
			end
		end
		return w;
	endfunction

	function automatic box_word_t uniform_box(logic [31:0] lo, logic [31:0] hi,
		logic [2:0][47:0] rows, logic [31:0] org);
		box_word_t w;
		w.bmin = {3{lo}};
		w.bmax = {3{hi}};
		w.rot = rows;
		w.org = {3{org}};
		return w;
	endfunction

	// ---------------- bound word checker ----------------

	task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		bounds_t want;
		if (arst_n && bound_valid && !bound_stall) begin
			if (bound_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected bound word: min %h %h %h max %h %h %h",
						glob_min_x, glob_min_y, glob_min_z,
						glob_max_x, glob_max_y, glob_max_z);
			end else begin
				want = bound_due.pop_front();
				flag_field(min_name[0], want.lo[0], glob_min_x);
				flag_field(min_name[1], want.lo[1], glob_min_y);
				flag_field(min_name[2], want.lo[2], glob_min_z);
				flag_field(max_name[0], want.hi[0], glob_max_x);
				flag_field(max_name[1], want.hi[1], glob_max_y);
				flag_field(max_name[2], want.hi[2], glob_max_z);
				flag_field("saturated", want.sat, saturated);
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		if (sink_hold_req) begin
			sink_hold_left = HOLD_CYCLES;
			sink_hold_req = 1'b0;
		end
		if (sink_hold_left > 0) begin
			sink_hold_left--;
			bound_stall <= 1'b1;
		end else begin
			if (sink_run > 0) begin
				sink_run--;
			end else begin
				sink_busy = sink_idle_en && ($urandom_range(0, 2) == 0);
				sink_run = sink_busy ? idle_len() : $urandom_range(0, 6);
			end
			bound_stall <= sink_busy;
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_box(box_word_t w);
		bounds_t want;
		int gap;
		want = predict_bounds(w);
		@(negedge clk);
		item_valid <= 1'b1;
		box_min_x <= w.bmin[0];
		box_min_y <= w.bmin[1];
		box_min_z <= w.bmin[2];
		box_max_x <= w.bmax[0];
		box_max_y <= w.bmax[1];
		box_max_z <= w.bmax[2];
		elem_rot_row0 <= w.rot[0];
		elem_rot_row1 <= w.rot[1];
		elem_rot_row2 <= w.rot[2];
		elem_origin_x <= w.org[0];
		elem_origin_y <= w.org[1];
		elem_origin_z <= w.org[2];
		do
			@(posedge clk);
		while (item_stall);
		bound_due.push_back(want);
		gap = (src_idle_en && $urandom_range(0, 1) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (bound_due.size() != 0)
			@(posedge clk);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	task automatic write_stage_reg(bxtb_pkg::reg_idx_t idx, logic [63:0] val);
		logic [63:0] mask;
		mask = (idx <= bxtb_pkg::REG_STAGE_ROT_ROW2) ? 64'hFFFF_FFFF_FFFF : 64'hFFFF_FFFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bxtb_pkg::CfgAddrWidth'(32'(idx) << bxtb_pkg::RegIdxLsb);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			bxtb_pkg::REG_STAGE_ROT_ROW0: stage_rot[0] = val[47:0];
			bxtb_pkg::REG_STAGE_ROT_ROW1: stage_rot[1] = val[47:0];
			bxtb_pkg::REG_STAGE_ROT_ROW2: stage_rot[2] = val[47:0];
			bxtb_pkg::REG_STAGE_ORIGIN_X: stage_org[0] = val[31:0];
			bxtb_pkg::REG_STAGE_ORIGIN_Y: stage_org[1] = val[31:0];
			bxtb_pkg::REG_STAGE_ORIGIN_Z: stage_org[2] = val[31:0];
			default: ;
		endcase
		// read it back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		flag_field("prdata", val & mask, prdata & mask);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_stage(logic [2:0][47:0] rows, logic [2:0][31:0] org);
		write_stage_reg(bxtb_pkg::REG_STAGE_ROT_ROW0, {16'h0, rows[0]});
		write_stage_reg(bxtb_pkg::REG_STAGE_ROT_ROW1, {16'h0, rows[1]});
		write_stage_reg(bxtb_pkg::REG_STAGE_ROT_ROW2, {16'h0, rows[2]});
		write_stage_reg(bxtb_pkg::REG_STAGE_ORIGIN_X, {32'h0, org[0]});
		write_stage_reg(bxtb_pkg::REG_STAGE_ORIGIN_Y, {32'h0, org[1]});
		write_stage_reg(bxtb_pkg::REG_STAGE_ORIGIN_Z, {32'h0, org[2]});
	endtask

	// ---------------- tests ----------------

	// identity stage from reset: extremes, rounding, clamps, inverted box
	task automatic test_directed_corners();
		send_box(uniform_box(32'h0, 32'h0, IDENT_ROWS, 32'h0));
		send_box(uniform_box(32'h8000_0000, 32'h7FFF_FFFF, IDENT_ROWS, 32'h0));
		send_box(uniform_box(32'h8000_0000, 32'h7FFF_FFFF, NEG_TWO_ROWS, 32'h0));
		send_box(uniform_box(32'h8000_0000, 32'h7FFF_FFFF, MAX_ROWS, 32'h1234_5678));
		send_box(uniform_box(32'h0001_8000, 32'hFFFD_C000,
			{48'h0000_0000_4000, 48'hC000_0000_0000, 48'h0000_4000_0000}, 32'h0));
		// half-way rounding, positive and negative
		send_box(uniform_box(32'h0000_2000, 32'h0000_2000, {3{48'h0000_0000_0001}}, 32'h0));
		send_box(uniform_box(32'hFFFF_E000, 32'h0000_1FFF, {3{48'h0001_0001_0001}}, 32'h0));
		// origin add clamps on both sides
		send_box(uniform_box(32'h7FFF_0000, 32'h7FFF_FFFF, IDENT_ROWS, 32'h7FFF_FFFF));
		send_box(uniform_box(32'h8000_0000, 32'h8000_FFFF, IDENT_ROWS, 32'h8000_0000));
		send_box(uniform_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, {3{48'hFFFF_FFFF_FFFF}},
			32'hFFFF_FFFF));
		send_box(uniform_box(32'hAAAA_AAAA, 32'h5555_5555, {3{48'hAAAA_5555_AAAA}},
			32'h5555_AAAA));
		drain();
	endtask

	task automatic test_stage_extremes();
		for (int s = 0; s < 4; s++) begin
			case (s)
				0: program_stage(NEG_TWO_ROWS, {3{32'h8000_0000}});
				1: program_stage(MAX_ROWS, {3{32'h7FFF_FFFF}});
				2: program_stage('0, {$urandom, $urandom, $urandom});
				default: program_stage(IDENT_ROWS, '0);
			endcase
			send_box(uniform_box(32'h8000_0000, 32'h7FFF_FFFF, IDENT_ROWS, 32'h0));
			send_box(random_box());
			send_box(uniform_box(32'hFFFF_0000, 32'h0001_0000, MAX_ROWS, 32'h0000_8000));
			drain();
		end
	endtask

	task automatic test_random_stream();
		logic [2:0][47:0] rows;
		logic [2:0][31:0] org;
		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < bxtb_pkg::NumAxes; i++) begin
				rows[i] = ($urandom_range(0, 3) == 0) ? bits48() : rot_row_rand();
				org[i] = coord_rand();
			end
			program_stage(rows, org);
			// one phase runs flat out on both sides
			src_idle_en = (ph != 2);
			sink_idle_en = (ph != 2);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_box(random_box());
			drain();
		end
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// receiver holds off while words keep coming, so the pipe backs up
	task automatic test_backpressure();
		src_idle_en = 1'b0;
		sink_hold_req = 1'b1;
		for (int n = 0; n < 40; n++)
			send_box(random_box());
		src_idle_en = 1'b1;
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_corners();
		test_stage_extremes();
		test_backpressure();
		test_random_stream();
		drain();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
